FILE: rtl/msrt_pkg.sv
`timescale 1ns / 1ps

package msrt_pkg;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    localparam logic [7:0] ADDR_CMD   = 8'hEA;
    localparam logic [7:0] WRITE_FLAG = 8'h80;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    typedef logic [2:0] len_t;

    // data length in bytes for a register address, 0 when unknown or for a read of ADDR_CMD
    function automatic len_t table_length(input logic [7:0] addr, input logic wr);
        len_t len;
        len = 3'd0;
        if (addr == ADDR_CMD) begin
            len = wr ? 3'd1 : 3'd0;
        end else begin
            case (addr) inside
                8'h07, 8'h08, [8'h40:8'h43]:                        len = 3'd1;
                [8'h00:8'h06], [8'h09:8'h17], 8'h20, 8'h21, 8'h25,
                8'h45:                                              len = 3'd2;
                [8'h22:8'h24], [8'h29:8'h2D], [8'h30:8'h32], 8'h35,
                8'h7F:                                              len = 3'd3;
                [8'h26:8'h28], 8'h44:                               len = 3'd4;
                default:                                            len = 3'd0;
            endcase
        end
        return len;
    endfunction

endpackage

FILE: rtl/meter_spi_register_transfer_unit.sv
`timescale 1ns / 1ps

// SPI master for the register file of a metering chip, one serial bit slot per word.
// Input channel s_*: s_tuser carries the mode (tick, start read, start write);
// s_tdata carries the register address, write data and the sampled MISO bit.
// A start word latches the address, looks up the data length and pulls chip
// select low. Each following tick word issues one serial clock: 8 address bits
// MSB first, then 8 bits per data byte out (write) or in (read). The last slot
// raises chip select and done; unknown addresses end after the address byte.
// Output channel m_*: one result word per input word, carrying chip select,
// clock pulse, MOSI bit, busy/done, read data, byte count and unknown flag.
// Each result is held in a single output register; a word is accepted in every
// cycle while that register is empty or its result is taken in the same cycle.
// When the receiver stalls, the result holds in the output register and the
// input is held off until it is taken, so nothing is lost or repeated.
// Reset (aresetn low, synchronous) ends any transfer: idle, chip select high,
// output register empty.
module meter_spi_register_transfer_unit
    import msrt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // reg_address[7:0], write_value[39:8], miso_bit[40], zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // chip_select_n[0], clock_pulse[1], mosi_bit[2], busy_res[3], done_res[4],
    // read_value[36:5], byte_count[39:37], unknown_address[40], zero fill
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic        active_reg,   active_next;
    logic        writing_reg,  writing_next;
    logic [5:0]  slot_reg,     slot_next;
    len_t        len_reg,      len_next;
    logic [39:0] tx_reg,       tx_next;
    logic [31:0] rx_reg,       rx_next;
    logic        out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic        s_accept;
    logic [1:0]  mode;
    logic [7:0]  addr;
    logic [31:0] wval;
    logic        miso;
    logic        wr;
    len_t        start_len;
    logic [7:0]  abyte;
    logic [31:0] wdata;
    logic        clk_pulse, mosi, done;
    logic [31:0] rval;
    logic        show_len;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign mode = s_tuser;
    assign addr = s_tdata[7:0];
    assign wval = s_tdata[39:8];
    assign miso = s_tdata[40];

    assign wr        = (mode == MODE_WRITE);
    assign start_len = table_length(addr, wr);

    always_comb begin
        abyte = addr;
        if (wr && addr != ADDR_CMD) begin
            abyte = addr | WRITE_FLAG;
        end
        wdata = '0;
        if (wr) begin
            case (start_len)
                3'd1:    wdata = {wval[7:0], 24'd0};
                3'd2:    wdata = {wval[15:0], 16'd0};
                3'd3:    wdata = {wval[23:0], 8'd0};
                3'd4:    wdata = wval;
                default: wdata = '0;
            endcase
        end
    end

    always_comb begin
        active_next  = active_reg;
        writing_next = writing_reg;
        slot_next    = slot_reg;
        len_next     = len_reg;
        tx_next      = tx_reg;
        rx_next      = rx_reg;
        clk_pulse    = 1'b0;
        mosi         = 1'b0;
        done         = 1'b0;
        rval         = '0;
        if (!active_reg && (mode == MODE_READ || mode == MODE_WRITE)) begin
            active_next  = 1'b1;
            writing_next = wr;
            slot_next    = '0;
            len_next     = start_len;
            tx_next      = {abyte, wdata};
            rx_next      = '0;
        end else if (active_reg && mode == MODE_TICK) begin
            clk_pulse = 1'b1;
            mosi      = tx_reg[39];
            // data phase of a read: sample miso, drive mosi low
            if (slot_reg >= 6'd8 && !writing_reg) begin
                mosi    = 1'b0;
                rx_next = {rx_reg[30:0], miso};
            end
            tx_next = {tx_reg[38:0], 1'b0};
            // last slot is 8 * (len + 1) - 1
            if (slot_reg >= {len_reg, 3'b111}) begin
                done        = 1'b1;
                active_next = 1'b0;
                if (!writing_reg && len_reg != 3'd0) begin
                    rval = rx_next;
                end
            end
            slot_next = slot_reg + 6'd1;
        end
        show_len = active_next || done;
        out_data_next = {7'd0,
                         show_len && (len_next == 3'd0),
                         show_len ? len_next : 3'd0,
                         rval, done, active_next, mosi, clk_pulse, !active_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            writing_reg   <= 1'b0;
            slot_reg      <= '0;
            len_reg       <= '0;
            tx_reg        <= '0;
            rx_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                active_reg  <= active_next;
                writing_reg <= writing_next;
                slot_reg    <= slot_next;
                len_reg     <= len_next;
                tx_reg      <= tx_next;
                rx_reg      <= rx_next;
            end
            if (s_accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    a_done_has_clock: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[1])
        else $error("done without a serial clock");

    a_read_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[36:5] != 32'd0) |-> m_tdata[4])
        else $error("read data outside the done slot");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> $stable(active_reg) && $stable(slot_reg))
        else $error("transfer state moved without an input word");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");
`endif

endmodule
